/* rtl/core/slta_pkg.sv */
`timescale 1ns / 1ps

package slta_pkg;

  localparam int INDEX_BITS_DEF = 16;
  localparam int BIAS_W         = 16;
  localparam int VERTEX_W       = 24;
  localparam int CORNER_W       = VERTEX_W + 1;
  localparam int MATERIAL_W     = 16;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 24;

  localparam logic [CFG_IDX_W-1:0] REG_STRIP_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_PARITY = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MATERIAL_TAG = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INDEX_BIAS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_LIMIT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_VERTEX  = 3'd5;

  localparam logic signed [MATERIAL_W-1:0] MATERIAL_NONE = -16'sd1;

  typedef struct packed {
    logic [BIAS_W-1:0]   bias;
    logic [VERTEX_W-1:0] limit;
    logic [VERTEX_W-1:0] base;
  } rebase_cfg_t;

endpackage

/* rtl/core/strip_list_triangle_assembler_unit.sv */
`timescale 1ns / 1ps
// a triangle's closing index transfer fills the candidate stage, which passes it on to the result register on out_valid
// throughput: one index per cycle, limited only by out_stall on the result register
// the assembly state (two held indices, fill count, parity) updates in the transfer cycle
// reset: synchronous on rst_n low; state and pipeline empty, registers at their defaults
// strip_mode 0, start_parity 0, material_tag -1, bias, limit and base vertex 0

module strip_list_triangle_assembler_unit #(
  parameter int INDEX_BITS = slta_pkg::INDEX_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [INDEX_BITS-1:0]                  in_vertex_index,
  input  logic                                   in_block_last,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [slta_pkg::CORNER_W-1:0]          out_corner_first,
  output logic [slta_pkg::CORNER_W-1:0]          out_corner_second,
  output logic [slta_pkg::CORNER_W-1:0]          out_corner_third,
  output logic signed [slta_pkg::MATERIAL_W-1:0] out_triangle_material,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [slta_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [slta_pkg::CFG_DATA_W-1:0]        cfg_data
);

  // configuration registers
  logic                                   strip_mode_r;
  logic                                   start_parity_r;
  logic signed [slta_pkg::MATERIAL_W-1:0] material_r;
  slta_pkg::rebase_cfg_t                  rb_cfg_r;

  // assembly state
  logic [INDEX_BITS-1:0] older_r, older_nxt;
  logic [INDEX_BITS-1:0] newer_r, newer_nxt;
  logic [1:0]            fill_r, fill_nxt;
  logic                  par_r, par_nxt;

  // candidate triangle stage
  logic                  v1_r, v1_nxt;
  logic [INDEX_BITS-1:0] a_r, b_r, c_r;
  logic [INDEX_BITS-1:0] a_nxt, b_nxt, c_nxt;
  logic                  emit;

  // result stage
  logic                            v2_r, v2_nxt;
  logic [slta_pkg::CORNER_W-1:0]   first_r, second_r, third_r;
  logic signed [slta_pkg::MATERIAL_W-1:0] mat_r;
  logic [slta_pkg::CORNER_W-1:0]   ra, rb, rc;
  logic                            oka, okb, okc;

  logic in_accept;
  logic cfg_write;
  logic adv;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;
  assign in_accept = in_valid && !in_stall;
  assign adv       = v1_r && (!v2_r || !out_stall);
  assign in_stall  = v1_r && !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strip_mode_r   <= 1'b0;
      start_parity_r <= 1'b0;
      material_r     <= slta_pkg::MATERIAL_NONE;
      rb_cfg_r       <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        slta_pkg::REG_STRIP_MODE:   strip_mode_r   <= cfg_data[0];
        slta_pkg::REG_START_PARITY: start_parity_r <= cfg_data[0];
        slta_pkg::REG_MATERIAL_TAG: material_r     <= cfg_data[slta_pkg::MATERIAL_W-1:0];
        slta_pkg::REG_INDEX_BIAS:   rb_cfg_r.bias  <= cfg_data[slta_pkg::BIAS_W-1:0];
        slta_pkg::REG_VERTEX_LIMIT: rb_cfg_r.limit <= cfg_data[slta_pkg::VERTEX_W-1:0];
        slta_pkg::REG_BASE_VERTEX:  rb_cfg_r.base  <= cfg_data[slta_pkg::VERTEX_W-1:0];
        default: ;
      endcase
    end
  end

  // index assembly
  always_comb begin
    older_nxt = older_r;
    newer_nxt = newer_r;
    fill_nxt  = fill_r;
    par_nxt   = par_r;
    emit      = 1'b0;
    a_nxt     = older_r;
    b_nxt     = in_vertex_index;
    c_nxt     = newer_r;
    if (in_accept) begin
      priority if (fill_r >= 2'd2) begin
        if (strip_mode_r) begin
          emit = (older_r != newer_r) && (newer_r != in_vertex_index)
                 && (older_r != in_vertex_index);
          if (par_r) begin
            b_nxt = newer_r;
            c_nxt = in_vertex_index;
          end
          par_nxt   = !par_r;
          older_nxt = newer_r;
          newer_nxt = in_vertex_index;
        end else begin
          emit     = 1'b1;
          fill_nxt = 2'd0;
        end
      end else if (fill_r == 2'd1) begin
        newer_nxt = in_vertex_index;
        fill_nxt  = 2'd2;
      end else begin
        older_nxt = in_vertex_index;
        fill_nxt  = 2'd1;
      end
      if (in_block_last) begin
        older_nxt = '0;
        newer_nxt = '0;
        fill_nxt  = 2'd0;
        par_nxt   = start_parity_r;
      end
    end
    if (cfg_write && cfg_index == slta_pkg::REG_START_PARITY) begin
      par_nxt = cfg_data[0];
    end
  end

  always_comb begin
    v1_nxt = v1_r;
    if (in_accept) begin
      v1_nxt = emit;
    end else if (adv) begin
      v1_nxt = 1'b0;
    end
  end

  slta_rebase #(.INDEX_BITS(INDEX_BITS)) u_rebase_a (
    .idx(a_r), .cfg(rb_cfg_r), .ok(oka), .corner(ra)
  );
  slta_rebase #(.INDEX_BITS(INDEX_BITS)) u_rebase_b (
    .idx(b_r), .cfg(rb_cfg_r), .ok(okb), .corner(rb)
  );
  slta_rebase #(.INDEX_BITS(INDEX_BITS)) u_rebase_c (
    .idx(c_r), .cfg(rb_cfg_r), .ok(okc), .corner(rc)
  );

  always_comb begin
    v2_nxt = v2_r;
    if (adv) begin
      v2_nxt = oka && okb && okc;
    end else if (v2_r && !out_stall) begin
      v2_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      older_r <= '0;
      newer_r <= '0;
      fill_r  <= 2'd0;
      par_r   <= 1'b0;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
    end else begin
      older_r <= older_nxt;
      newer_r <= newer_nxt;
      fill_r  <= fill_nxt;
      par_r   <= par_nxt;
      v1_r    <= v1_nxt;
      v2_r    <= v2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      a_r <= a_nxt;
      b_r <= b_nxt;
      c_r <= c_nxt;
    end
    if (adv) begin
      first_r  <= ra;
      second_r <= rb;
      third_r  <= rc;
      mat_r    <= material_r;
    end
  end

  assign out_valid             = v2_r;
  assign out_corner_first      = first_r;
  assign out_corner_second     = second_r;
  assign out_corner_third      = third_r;
  assign out_triangle_material = mat_r;

  a_fill_range : assert property (@(posedge clk) disable iff (!rst_n)
    fill_r != 2'd3)
    else $error("fill count out of range");

  a_last_clears : assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_block_last) |=> (fill_r == 2'd0 && older_r == '0 && newer_r == '0
                                      && par_r == start_parity_r))
    else $error("block end did not clear assembly state");

  a_full_stalls : assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && v2_r && out_stall) |-> in_stall)
    else $error("input taken while both stages are blocked");

  a_result_held : assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && out_stall && !adv) |=> (v2_r && $stable(first_r) && $stable(third_r)))
    else $error("result register changed while blocked");

endmodule

/* rtl/core/slta_rebase.sv */
`timescale 1ns / 1ps

module slta_rebase #(
  parameter int INDEX_BITS = slta_pkg::INDEX_BITS_DEF
) (
  input  logic [INDEX_BITS-1:0]          idx,
  input  slta_pkg::rebase_cfg_t          cfg,
  output logic                           ok,
  output logic [slta_pkg::CORNER_W-1:0]  corner
);

  localparam int W = (INDEX_BITS > slta_pkg::VERTEX_W) ? INDEX_BITS : slta_pkg::VERTEX_W;

  logic [W-1:0] idx_w;
  logic [W-1:0] bias_w;
  logic [W-1:0] lim_w;
  logic [W-1:0] diff;
  logic         below;

  assign idx_w  = W'(idx);
  assign bias_w = W'(cfg.bias);
  assign lim_w  = W'(cfg.limit);
  assign below  = idx_w < bias_w;
  assign diff   = idx_w - bias_w;
  assign ok     = !below && (diff < lim_w);
  assign corner = {1'b0, diff[slta_pkg::VERTEX_W-1:0]} + {1'b0, cfg.base};

endmodule
